// ===== hdl/wbrs_pkg.sv =====
package wbrs_pkg;

    // datapath widths
    localparam int XW     = 30;   // cordic x / y and sine / cosine values, q24
    localparam int ZW     = 27;   // angles in degrees * 65536
    localparam int AW     = 17;   // angles in degrees * 256
    localparam int QDEPTH = 2;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 25;

    localparam logic signed [ZW-1:0] HALF16  = ZW'(11796480);
    localparam logic signed [ZW-1:0] FULL16  = ZW'(23592960);
    localparam logic signed [ZW-1:0] QUART16 = ZW'(5898240);
    localparam logic signed [ZW-1:0] ROUND8  = ZW'(128);
    localparam logic signed [XW-1:0] KGAIN   = XW'(10188012);
    localparam logic [AW-1:0]        FULL8   = AW'(92160);
    localparam logic [AW-1:0]        HALF8   = AW'(46080);

    typedef enum logic [CFG_IW-1:0] {
        REG_MARKER_LAT     = 3'd0,
        REG_MARKER_LON     = 3'd1,
        REG_HEADING_OFFSET = 3'd2,
        REG_DEADBAND       = 3'd3,
        REG_RUDDER_STEP    = 3'd4,
        REG_RUDDER_MIN     = 3'd5,
        REG_RUDDER_MAX     = 3'd6
    } reg_index_t;

    typedef enum logic {
        CM_ROT,
        CM_VEC
    } cordic_mode_t;

    typedef struct packed {
        logic signed [23:0] marker_lat;
        logic signed [24:0] marker_lon;
        logic signed [16:0] heading_offset;
        logic [15:0]        deadband;
        logic [7:0]         rudder_step;
        logic signed [8:0]  rudder_min;
        logic [7:0]         rudder_max;
    } cfg_t;

    typedef struct packed {
        logic [AW-1:0]      curr;
        logic signed [23:0] blat;
        logic signed [25:0] dlon;
    } item_t;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           full;
        logic           empty;
    } q_stat_t;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } fold_t;

    // atan(2^-i) in degrees * 65536
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW-1:0] t;
        case (i)
            5'd0:  t = ZW'(2949120);
            5'd1:  t = ZW'(1740967);
            5'd2:  t = ZW'(919879);
            5'd3:  t = ZW'(466945);
            5'd4:  t = ZW'(234379);
            5'd5:  t = ZW'(117304);
            5'd6:  t = ZW'(58666);
            5'd7:  t = ZW'(29335);
            5'd8:  t = ZW'(14668);
            5'd9:  t = ZW'(7334);
            5'd10: t = ZW'(3667);
            5'd11: t = ZW'(1833);
            5'd12: t = ZW'(917);
            5'd13: t = ZW'(458);
            5'd14: t = ZW'(229);
            5'd15: t = ZW'(115);
            5'd16: t = ZW'(57);
            5'd17: t = ZW'(29);
            5'd18: t = ZW'(14);
            5'd19: t = ZW'(7);
            5'd20: t = ZW'(4);
            5'd21: t = ZW'(2);
            5'd22: t = ZW'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

    // wrap into [-180,180) then fold into [-90,90]; input stays within +-2^25
    function automatic fold_t fold_angle(input logic signed [ZW-1:0] a);
        fold_t r;
        logic signed [ZW-1:0] w;
        if (a >= HALF16)
            w = a - FULL16;
        else if (a < -HALF16)
            w = a + FULL16;
        else
            w = a;
        if (w > QUART16) begin
            r.z = w - HALF16;
            r.neg = 1'b1;
        end
        else if (w < -QUART16) begin
            r.z = w + HALF16;
            r.neg = 1'b1;
        end
        else begin
            r.z = w;
            r.neg = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== hdl/wbrs_front.sv =====
module wbrs_front
    import wbrs_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [16:0] boat_heading,
    input  logic signed [23:0] boat_lat,
    input  logic signed [24:0] boat_lon,
    input  cfg_t               cfg,
    input  logic               q_full,
    output logic               push,
    output item_t              item
);

    logic signed [18:0] head_sum;
    logic signed [18:0] head_wrap;

    // heading + 180 + offset, wrapped once into [0,360)
    always_comb
    begin
        head_sum = 19'(boat_heading) + 19'(signed'({1'b0, HALF8}))
                 + 19'(cfg.heading_offset);
        if (head_sum < 0)
            head_wrap = head_sum + 19'(signed'({1'b0, FULL8}));
        else if (head_sum >= 19'(signed'({1'b0, FULL8})))
            head_wrap = head_sum - 19'(signed'({1'b0, FULL8}));
        else
            head_wrap = head_sum;
    end

    assign item.curr = head_wrap[AW-1:0];
    assign item.blat = boat_lat;
    assign item.dlon = 26'(cfg.marker_lon) - 26'(boat_lon);

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

endmodule

// ===== hdl/wbrs_queue.sv =====
module wbrs_queue
    import wbrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   item_in,
    input  logic    pop,
    output item_t   item_out,
    output logic    q_valid,
    output q_stat_t stat
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    item_t          entry_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign item_out   = entry_reg[rd_ptr_reg];
    assign q_valid    = (count_reg != '0);
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== hdl/wbrs_cordic.sv =====
module wbrs_cordic
    import wbrs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cordic_mode_t         mode,
    input  logic signed [XW-1:0] x0,
    input  logic signed [XW-1:0] y0,
    input  logic signed [ZW-1:0] z0,
    output logic                 done,
    output logic signed [XW-1:0] x,
    output logic signed [XW-1:0] y,
    output logic signed [ZW-1:0] z
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    cordic_mode_t         mode_reg;

    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [ZW-1:0] ang;
    logic                 up;

    always_comb
    begin
        sx  = x_reg >>> cnt_reg;
        sy  = y_reg >>> cnt_reg;
        ang = atan_tab(5'(cnt_reg));
        // rotate toward z = 0, or vector toward y = 0
        up  = (mode_reg == CM_ROT) ? !z_reg[ZW-1] : y_reg[XW-1];
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            mode_reg <= mode;
        end
        else if (busy_reg) begin
            if (up) begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - ang;
            end
            else begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == IW'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// ===== hdl/wbrs_back.sv =====
module wbrs_back
    import wbrs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [8:0]  servo_position,
    output logic               send_pulse,
    output logic [16:0]        bearing,
    output logic [15:0]        heading_error
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SST   = 7'b0000010,
        S_SC    = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_VST   = 7'b0010000,
        S_VEC   = 7'b0100000,
        S_STEER = 7'b1000000
    } state_t;

    localparam logic [1:0] SC_BLAT = 2'd0;
    localparam logic [1:0] SC_MLAT = 2'd1;
    localparam logic [1:0] SC_DLON = 2'd2;

    state_t                 state_reg;
    item_t                  item_reg;
    logic [1:0]             sc_idx_reg;
    logic                   neg_reg;
    logic [2:0]             mcnt_reg;
    logic signed [XW-1:0]   sb_reg, cb_reg, sm_reg, cm_reg, sd_reg, cd_reg;
    logic signed [XW-1:0]   p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [2*XW-1:0] prod_reg;
    logic [AW-1:0]          bearing_reg;
    logic signed [8:0]      servo_pos_reg;
    logic                   out_valid_reg;
    logic                   send_reg;
    logic [AW-1:0]          bear_out_reg;
    logic [15:0]            err_out_reg;

    // shared cordic
    logic                 cs_start;
    cordic_mode_t         cs_mode;
    logic signed [XW-1:0] cs_x0, cs_y0;
    logic signed [ZW-1:0] cs_z0;
    logic                 c_done;
    logic signed [XW-1:0] c_x, c_y;
    logic signed [ZW-1:0] c_z;

    logic signed [ZW-1:0] sc_angle;
    fold_t                sc_fold;
    logic signed [XW-1:0] s_val, c_val;
    logic signed [XW-1:0] op_a, op_b;
    logic signed [XW-1:0] p_shift;
    logic signed [XW-1:0] den;
    logic signed [ZW-1:0] z_rnd;
    logic signed [ZW-9:0] z_deg8;
    logic signed [ZW-9:0] bear_wrap;

    logic [AW-1:0]        right, left, err;
    logic signed [9:0]    lsum, rdiff, pos_ext;
    logic                 out_free;
    logic                 step_dn, step_up;

    wbrs_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cs_start),
        .mode  (cs_mode),
        .x0    (cs_x0),
        .y0    (cs_y0),
        .z0    (cs_z0),
        .done  (c_done),
        .x     (c_x),
        .y     (c_y),
        .z     (c_z)
    );

    always_comb
    begin
        case (sc_idx_reg)
            SC_BLAT: sc_angle = ZW'(item_reg.blat);
            SC_MLAT: sc_angle = ZW'(cfg.marker_lat);
            default: sc_angle = ZW'(item_reg.dlon);
        endcase
        sc_fold = fold_angle(sc_angle);
        s_val   = neg_reg ? -c_y : c_y;
        c_val   = neg_reg ? -c_x : c_x;

        case (mcnt_reg[2:1])
            2'd0:    begin op_a = sd_reg; op_b = cm_reg; end
            2'd1:    begin op_a = cb_reg; op_b = sm_reg; end
            2'd2:    begin op_a = sb_reg; op_b = cm_reg; end
            default: begin op_a = p3_reg; op_b = cd_reg; end
        endcase
        p_shift = XW'(prod_reg >>> 24);

        den      = p2_reg - p4_reg;
        cs_start = 1'b0;
        cs_mode  = CM_ROT;
        cs_x0    = KGAIN;
        cs_y0    = '0;
        cs_z0    = sc_fold.z;
        if (state_reg == S_SST) begin
            cs_start = 1'b1;
        end
        else if (state_reg == S_VST) begin
            cs_start = 1'b1;
            cs_mode  = CM_VEC;
            if (den < 0) begin
                cs_x0 = -den;
                cs_y0 = -p1_reg;
                cs_z0 = p1_reg[XW-1] ? -HALF16 : HALF16;
            end
            else begin
                cs_x0 = den;
                cs_y0 = p1_reg;
                cs_z0 = '0;
            end
        end

        z_rnd     = c_z + ROUND8;
        z_deg8    = (ZW-8)'(z_rnd >>> 8);
        bear_wrap = z_deg8[ZW-9] ? z_deg8 + (ZW-8)'(signed'({1'b0, FULL8})) : z_deg8;

        // steering decision
        if (bearing_reg < item_reg.curr)
            right = FULL8 - item_reg.curr + bearing_reg;
        else
            right = bearing_reg - item_reg.curr;
        left    = FULL8 - right;
        err     = (left < right) ? left : right;
        lsum    = 10'(cfg.rudder_min) + 10'(signed'({2'b00, cfg.rudder_step}));
        rdiff   = 10'(signed'({2'b00, cfg.rudder_max}))
                - 10'(signed'({2'b00, cfg.rudder_step}));
        pos_ext = 10'(servo_pos_reg);
        step_dn = 1'b0;
        step_up = 1'b0;
        if (err > {1'b0, cfg.deadband}) begin
            if (err == left && lsum <= pos_ext)
                step_dn = 1'b1;
            else if (err == right && rdiff >= pos_ext)
                step_up = 1'b1;
        end
        out_free = !out_valid_reg || out_ready;
    end

    assign pop = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE: begin
                item_reg <= q_item;
            end
            S_SST: begin
                neg_reg <= sc_fold.neg;
            end
            S_SC: begin
                if (c_done) begin
                    case (sc_idx_reg)
                        SC_BLAT: begin sb_reg <= s_val; cb_reg <= c_val; end
                        SC_MLAT: begin sm_reg <= s_val; cm_reg <= c_val; end
                        default: begin sd_reg <= s_val; cd_reg <= c_val; end
                    endcase
                end
            end
            S_MUL: begin
                if (!mcnt_reg[0]) begin
                    prod_reg <= op_a * op_b;
                end
                else begin
                    case (mcnt_reg[2:1])
                        2'd0:    p1_reg <= p_shift;
                        2'd1:    p2_reg <= p_shift;
                        2'd2:    p3_reg <= p_shift;
                        default: p4_reg <= p_shift;
                    endcase
                end
            end
            S_VEC: begin
                if (c_done)
                    bearing_reg <= AW'(bear_wrap);
            end
            S_STEER: begin
                if (out_free) begin
                    send_reg     <= step_dn || step_up;
                    bear_out_reg <= bearing_reg;
                    err_out_reg  <= err[15:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            sc_idx_reg    <= SC_BLAT;
            mcnt_reg      <= '0;
            servo_pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    sc_idx_reg <= SC_BLAT;
                    if (q_valid)
                        state_reg <= S_SST;
                end
                S_SST: begin
                    state_reg <= S_SC;
                end
                S_SC: begin
                    if (c_done) begin
                        if (sc_idx_reg == SC_DLON) begin
                            mcnt_reg  <= '0;
                            state_reg <= S_MUL;
                        end
                        else begin
                            sc_idx_reg <= sc_idx_reg + 1'b1;
                            state_reg  <= S_SST;
                        end
                    end
                end
                S_MUL: begin
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 3'd7)
                        state_reg <= S_VST;
                end
                S_VST: begin
                    state_reg <= S_VEC;
                end
                S_VEC: begin
                    if (c_done)
                        state_reg <= S_STEER;
                end
                S_STEER: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        if (step_dn)
                            servo_pos_reg <= servo_pos_reg
                                           - 9'(signed'({1'b0, cfg.rudder_step}));
                        else if (step_up)
                            servo_pos_reg <= servo_pos_reg
                                           + 9'(signed'({1'b0, cfg.rudder_step}));
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_position = servo_pos_reg;
    assign send_pulse     = send_reg;
    assign bearing        = bear_out_reg;
    assign heading_error  = err_out_reg;

endmodule

// ===== hdl/waypoint_bearing_rudder_stepper_unit.sv =====
// items are handled one at a time: the back end pops the next only when idle, its pace set
//   by the single shared cordic unit that runs three sine/cosine passes and one arctangent
//   pass per item
// a two-item queue after the front lets inputs be taken while the back is busy
// reset: asynchronous, active low; registers take their documented defaults,
//   servo position returns to center and the queue empties
module waypoint_bearing_rudder_stepper_unit
    import wbrs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [16:0]  boat_heading,
    input  logic signed [23:0]  boat_lat,
    input  logic signed [24:0]  boat_lon,
    // result items
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [8:0]   servo_position,
    output logic                send_pulse,
    output logic [16:0]         bearing,
    output logic [15:0]         heading_error
);

    cfg_t    cfg_reg;
    logic    push;
    item_t   front_item;
    item_t   q_item;
    logic    q_valid;
    logic    pop;
    q_stat_t q_stat;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.marker_lat     <= '0;
            cfg_reg.marker_lon     <= '0;
            cfg_reg.heading_offset <= '0;
            cfg_reg.deadband       <= 16'd3840;
            cfg_reg.rudder_step    <= 8'd1;
            cfg_reg.rudder_min     <= -9'sd150;
            cfg_reg.rudder_max     <= 8'd150;
        end
        else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_MARKER_LAT:     cfg_reg.marker_lat     <= cfg_wdata[23:0];
                REG_MARKER_LON:     cfg_reg.marker_lon     <= cfg_wdata[24:0];
                REG_HEADING_OFFSET: cfg_reg.heading_offset <= cfg_wdata[16:0];
                REG_DEADBAND:       cfg_reg.deadband       <= cfg_wdata[15:0];
                REG_RUDDER_STEP:    cfg_reg.rudder_step    <= cfg_wdata[7:0];
                REG_RUDDER_MIN:     cfg_reg.rudder_min     <= cfg_wdata[8:0];
                REG_RUDDER_MAX:     cfg_reg.rudder_max     <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // front: takes items, wraps the heading, forms the longitude difference
    wbrs_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .boat_heading (boat_heading),
        .boat_lat     (boat_lat),
        .boat_lon     (boat_lon),
        .cfg          (cfg_reg),
        .q_full       (q_stat.full),
        .push         (push),
        .item         (front_item)
    );

    // queue decoupling the front from the cordic back end
    wbrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (q_item),
        .q_valid  (q_valid),
        .stat     (q_stat)
    );

    // back: bearing by cordic, steering decision, servo state, output register
    wbrs_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .servo_position (servo_position),
        .send_pulse     (send_pulse),
        .bearing        (bearing),
        .heading_error  (heading_error)
    );

    // results stay inside the angle ranges
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_error <= HALF8[15:0] && bearing < FULL8))
        else $error("result angle out of range");

    // an accepted item is always held in the queue afterwards
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_stat.empty)
        else $error("accepted item lost from queue");

    // queue never overfills
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCW'(QDEPTH))
        else $error("queue overflow");

endmodule

// ===== bench/tb_waypoint_bearing_rudder_stepper_unit.sv =====
`timescale 1ns / 1ps

module tb_waypoint_bearing_rudder_stepper_unit
    import wbrs_pkg::*;
();

    localparam int STEPS = 16;
    // index 7 has no register behind it, writes there must be dropped
    localparam logic [CFG_IW-1:0] REG_UNMAPPED = 3'd7;

    // angle constants, degrees * 65536 and degrees * 256
    localparam longint DEG_HALF  = 64'sd11796480;
    localparam longint DEG_FULL  = 64'sd23592960;
    localparam longint DEG_QUART = 64'sd5898240;
    localparam longint CIRCLE    = 64'sd92160;
    localparam longint SEMI      = 64'sd46080;
    localparam longint GAIN_Q24  = 64'sd10188012;

    typedef enum logic [1:0] {H_RAW, H_TIE, H_AT_DB, H_PAST_DB} aim_t;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        logic signed [8:0] pos;
        logic              pulse;
        logic [16:0]       brg;
        logic [15:0]       err;
    } rudder_res_t;

    typedef struct {
        row_kind_t          kind;
        logic [CFG_IW-1:0]  idx;
        logic [CFG_DW-1:0]  data;
        logic signed [16:0] hdg;
        logic signed [23:0] lat;
        logic signed [24:0] lon;
        aim_t               aim;
        bit [2:0]           typed;   // pos, pulse, err
        rudder_res_t        want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_IW-1:0]  cfg_index;
    logic [CFG_DW-1:0]  cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic signed [16:0] boat_heading;
    logic signed [23:0] boat_lat;
    logic signed [24:0] boat_lon;
    logic               out_valid;
    logic               out_ready;
    logic signed [8:0]  servo_position;
    logic               send_pulse;
    logic [16:0]        bearing;
    logic [15:0]        heading_error;

    waypoint_bearing_rudder_stepper_unit #(.CORDIC_STEPS(STEPS)) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .boat_heading    (boat_heading),
        .boat_lat        (boat_lat),
        .boat_lon        (boat_lon),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .servo_position  (servo_position),
        .send_pulse      (send_pulse),
        .bearing         (bearing),
        .heading_error   (heading_error)
    );

    // atan(2^-i) in degrees * 65536
    longint arc_steps [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    // shadow of the register file and the rudder state
    longint mk_lat, mk_lon, hdg_ofs, dead_band, step_sz, pos_lo, pos_hi;
    longint rudder;

    rudder_res_t pending_res[$];
    stim_row_t   plan[$];

    int  errors;
    int  n_items;
    int  n_results;
    int  n_pulses;
    int  n_ties;
    bit  steady;      // no idling on either side while set
    int  hold_len;    // request for a long receiver stall
    int  hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic longint modp(input longint v, input longint m);
        longint r;
        r = v % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    // rotation cordic, q24 sine and cosine of an angle in degrees * 65536
    function automatic void sin_cos(input longint a, output longint s, output longint c);
        longint x, y, z, nx;
        bit flip;
        x = GAIN_Q24;
        y = 0;
        flip = 1'b0;
        z = modp(a + DEG_HALF, DEG_FULL) - DEG_HALF;
        if (z > DEG_QUART)
        begin
            z -= DEG_HALF;
            flip = 1'b1;
        end
        else if (z < -DEG_QUART)
        begin
            z += DEG_HALF;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arc_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arc_steps[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // vectoring cordic, angle of (x, y) in degrees * 65536
    function automatic longint arc_tan2(input longint y_in, input longint x_in);
        longint x, y, z, nx;
        x = x_in;
        y = y_in;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? DEG_HALF : -DEG_HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arc_steps[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arc_steps[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint marker_azimuth(input longint blat, input longint blon);
        longint sb, cb, sm, cm, sd, cd, num, den;
        sin_cos(blat, sb, cb);
        sin_cos(mk_lat, sm, cm);
        sin_cos(mk_lon - blon, sd, cd);
        num = (sd * cm) >>> 24;
        den = ((cb * sm) >>> 24) - ((((sb * cm) >>> 24) * cd) >>> 24);
        return modp((arc_tan2(num, den) + 128) >>> 8, CIRCLE);
    endfunction

    // one rudder update; advances the shadow servo position
    function automatic rudder_res_t steer(input longint hdg, input longint blat,
                                          input longint blon);
        rudder_res_t r;
        longint brg, curr, right, left, err;
        brg = marker_azimuth(blat, blon);
        curr = modp(hdg + SEMI + hdg_ofs, CIRCLE);
        right = modp(brg - curr, CIRCLE);
        left = CIRCLE - right;
        err = (left < right) ? left : right;
        r.pulse = 1'b0;
        if (err > dead_band)
        begin
            if (err == left && pos_lo + step_sz <= rudder)
            begin
                rudder -= step_sz;
                r.pulse = 1'b1;
            end
            else if (err == right && pos_hi - step_sz >= rudder)
            begin
                rudder += step_sz;
                r.pulse = 1'b1;
            end
        end
        r.pos = rudder[8:0];
        r.brg = brg[16:0];
        r.err = err[15:0];
        return r;
    endfunction

    // heading that puts the right-turn error at a chosen value
    function automatic logic signed [16:0] aim_heading(input longint blat, input longint blon,
                                                       input longint right);
        longint h;
        h = modp(marker_azimuth(blat, blon) - right, CIRCLE) - SEMI - hdg_ofs;
        h = modp(h + SEMI, CIRCLE) - SEMI;
        return h[16:0];
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input longint d);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d[CFG_DW-1:0];
        case (idx)
            REG_MARKER_LAT:     mk_lat = longint'($signed(d[23:0]));
            REG_MARKER_LON:     mk_lon = longint'($signed(d[24:0]));
            REG_HEADING_OFFSET: hdg_ofs = longint'($signed(d[16:0]));
            REG_DEADBAND:       dead_band = longint'(d[15:0]);
            REG_RUDDER_STEP:    step_sz = longint'(d[7:0]);
            REG_RUDDER_MIN:     pos_lo = longint'($signed(d[8:0]));
            REG_RUDDER_MAX:     pos_hi = longint'(d[7:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one item, predict its result once accepted
    task automatic send_item(input logic signed [16:0] hdg, input logic signed [23:0] lat,
                             input logic signed [24:0] lon, input aim_t aim,
                             input bit [2:0] typed, input rudder_res_t want);
        rudder_res_t r;
        logic signed [16:0] h;
        h = hdg;
        case (aim)
            H_TIE:     h = aim_heading(lat, lon, SEMI);
            H_AT_DB:   h = aim_heading(lat, lon, dead_band);
            H_PAST_DB: h = aim_heading(lat, lon, dead_band + 1);
            default: ;
        endcase
        if (aim == H_TIE)
            n_ties++;
        if (!steady && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 33)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        boat_heading <= h;
        boat_lat <= lat;
        boat_lon <= lon;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = steer(h, lat, lon);
        if (typed[2])
            r.pos = want.pos;
        if (typed[1])
            r.pulse = want.pulse;
        if (typed[0])
            r.err = want.err;
        pending_res.push_back(r);
        n_items++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_cfg(input logic [CFG_IW-1:0] idx, input longint d);
        stim_row_t s;
        s = '{kind: ROW_CFG, aim: H_RAW, default: 0};
        s.idx = idx;
        s.data = d[CFG_DW-1:0];
        plan.push_back(s);
    endtask

    task automatic add_item(input longint hdg, input longint lat, input longint lon,
                            input aim_t aim, input bit [2:0] typed, input longint pos,
                            input bit pulse, input longint err);
        stim_row_t s;
        s = '{kind: ROW_ITEM, aim: H_RAW, default: 0};
        s.hdg = hdg[16:0];
        s.lat = lat[23:0];
        s.lon = lon[24:0];
        s.aim = aim;
        s.typed = typed;
        s.want.pos = pos[8:0];
        s.want.pulse = pulse;
        s.want.err = err[15:0];
        plan.push_back(s);
    endtask

    // result side: random back-pressure, long stalls on request, checking
    always @(posedge clk)
    begin
        rudder_res_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_res.size() == 0)
                begin
                    $display("%0t: result with no item outstanding: pos %0d", $time,
                             servo_position);
                    errors++;
                end
                else
                begin
                    e = pending_res.pop_front();
                    if (servo_position !== e.pos)
                    begin
                        $display("%0t: servo_position exp %0d got %0d", $time, e.pos,
                                 servo_position);
                        errors++;
                    end
                    if (send_pulse !== e.pulse)
                    begin
                        $display("%0t: send_pulse exp %0d got %0d", $time, e.pulse,
                                 send_pulse);
                        errors++;
                    end
                    if (bearing !== e.brg)
                    begin
                        $display("%0t: bearing exp %0d got %0d", $time, e.brg, bearing);
                        errors++;
                    end
                    if (heading_error !== e.err)
                    begin
                        $display("%0t: heading_error exp %0d got %0d", $time, e.err,
                                 heading_error);
                        errors++;
                    end
                    if (send_pulse === 1'b1)
                        n_pulses++;
                end
            end
            if (hold_left == 0 && hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin
        stim_row_t s;
        longint lat, lon, hdg;
        int pick;
        aim_t aim;
        rudder_res_t none;

        errors = 0;
        n_items = 0;
        n_results = 0;
        n_pulses = 0;
        n_ties = 0;
        steady = 1'b0;
        hold_len = 0;
        hold_left = 0;
        none = '{default: 0};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        boat_heading = '0;
        boat_lat = '0;
        boat_lon = '0;
        out_ready = 1'b0;

        // shadow state at reset
        mk_lat = 0;
        mk_lon = 0;
        hdg_ofs = 0;
        dead_band = 3840;
        step_sz = 1;
        pos_lo = -150;
        pos_hi = 150;
        rudder = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // items straight after reset run on the default registers
        add_item(0, 0, 0, H_RAW, 3'b000, 0, 0, 0);
        add_item(-46080, 5898240, -11796480, H_RAW, 3'b000, 0, 0, 0);
        // widest deadband: nothing can move the rudder, any field value allowed
        add_cfg(REG_DEADBAND, 46080);
        add_item(-65536, -8388608, -16777216, H_RAW, 3'b010, 0, 0, 0);
        add_item(65535, 8388607, 16777215, H_RAW, 3'b010, 0, 0, 0);
        add_item(46080, -5898240, 11796480, H_RAW, 3'b010, 0, 0, 0);
        // exact tie with the lower limit at zero: one side is always free, so it pulses
        add_cfg(REG_DEADBAND, 0);
        add_cfg(REG_RUDDER_MIN, 0);
        add_item(0, 655360, 1310720, H_TIE, 3'b011, 0, 1, 46080);
        add_item(0, 655360, 1310720, H_TIE, 3'b011, 0, 1, 46080);
        // zero step still reports a pulse without moving
        add_cfg(REG_RUDDER_STEP, 0);
        add_item(0, 655360, 1310720, H_PAST_DB, 3'b011, 0, 1, 1);
        add_item(0, 655360, 1310720, H_AT_DB, 3'b011, 0, 0, 0);
        // back to defaults, error exactly at the deadband stays put
        add_cfg(REG_RUDDER_STEP, 1);
        add_cfg(REG_RUDDER_MIN, -150);
        add_cfg(REG_DEADBAND, 3840);
        add_item(0, -3276800, 98304, H_AT_DB, 3'b011, 0, 0, 3840);
        add_item(0, -3276800, 98304, H_PAST_DB, 3'b000, 0, 0, 0);
        // marker off the origin, offsets at both extremes, ignored index
        add_cfg(REG_MARKER_LAT, 3932160);
        add_cfg(REG_MARKER_LON, -7864320);
        add_cfg(REG_HEADING_OFFSET, -46080);
        add_cfg(REG_UNMAPPED, 33554431);
        add_item(12800, 3932160, -7864320, H_RAW, 3'b000, 0, 0, 0);
        add_item(-30000, 3000000, -7000000, H_RAW, 3'b000, 0, 0, 0);
        add_cfg(REG_HEADING_OFFSET, 46080);
        add_item(30000, 5898240, 11796480, H_RAW, 3'b000, 0, 0, 0);
        add_item(0, -5898240, -11796480, H_TIE, 3'b000, 0, 0, 0);

        foreach (plan[k])
        begin
            s = plan[k];
            if (s.kind == ROW_CFG)
            begin
                drain();
                write_reg(s.idx, longint'(s.data));
            end
            else
                send_item(s.hdg, s.lat, s.lon, s.aim, s.typed, s.want);
        end

        // random part: eight settings, the first two fixed at extreme settings
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_reg(REG_MARKER_LAT, -5898240);
                    write_reg(REG_MARKER_LON, -11796480);
                    write_reg(REG_HEADING_OFFSET, -46080);
                    write_reg(REG_DEADBAND, 0);
                    write_reg(REG_RUDDER_STEP, 150);
                    write_reg(REG_RUDDER_MIN, -150);
                    write_reg(REG_RUDDER_MAX, 150);
                end
                1:
                begin
                    write_reg(REG_MARKER_LAT, 5898240);
                    write_reg(REG_MARKER_LON, 11796480);
                    write_reg(REG_HEADING_OFFSET, 46080);
                    write_reg(REG_DEADBAND, 46080);
                    write_reg(REG_RUDDER_STEP, 1);
                    write_reg(REG_RUDDER_MIN, 0);
                    write_reg(REG_RUDDER_MAX, 0);
                end
                default:
                begin
                    write_reg(REG_MARKER_LAT, longint'($urandom_range(11796480)) - 5898240);
                    write_reg(REG_MARKER_LON, longint'($urandom_range(23592960)) - 11796480);
                    write_reg(REG_HEADING_OFFSET, longint'($urandom_range(92160)) - 46080);
                    write_reg(REG_DEADBAND, ($urandom_range(3) == 0) ?
                              $urandom_range(46080) : $urandom_range(5000));
                    write_reg(REG_RUDDER_STEP, (ph == 5) ? 0 : $urandom_range(1, 40));
                    write_reg(REG_RUDDER_MIN, -longint'($urandom_range(150)));
                    write_reg(REG_RUDDER_MAX, $urandom_range(150));
                end
            endcase
            // the pressure phase: receiver stalls long while items keep coming
            if (ph == 2)
                hold_len = 600;
            steady = (ph == 3);
            for (int n = 0; n < 130; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    // near the marker, where the bearing swings the most
                    lat = mk_lat + longint'($urandom_range(262144)) - 131072;
                    lon = mk_lon + longint'($urandom_range(262144)) - 131072;
                end
                else if (pick < 88)
                begin
                    lat = longint'($signed($urandom_range(32'hFFFFFF) << 8)) >>> 8;
                    lon = longint'($signed($urandom_range(32'h1FFFFFF) << 7)) >>> 7;
                end
                else
                begin
                    // boat on the marker
                    lat = mk_lat;
                    lon = mk_lon;
                end
                pick = $urandom_range(99);
                if (pick < 85)
                    hdg = longint'($urandom_range(92160)) - 46080;
                else
                    hdg = longint'($signed($urandom_range(32'h1FFFF) << 15)) >>> 15;
                pick = $urandom_range(99);
                aim = (pick < 5) ? H_TIE : (pick < 9) ? H_AT_DB :
                      (pick < 13) ? H_PAST_DB : H_RAW;
                send_item(hdg[16:0], lat[23:0], lon[24:0], aim, 3'b000, none);
            end
            steady = 1'b0;
        end

        drain();
        repeat (4 * STEPS + 40) @(posedge clk);
        $display("covered %0d items and %0d results over 8 random settings plus directed rows",
                 n_items, n_results);
        $display("rudder pulses seen %0d, exact ties offered %0d", n_pulses, n_ties);
        if (errors == 0 && pending_res.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
